FILE: rtl/core/lwck_pkg.sv
// Shared types, constants and helper functions for the leg wheel center kinematics block.
// This package has no dependencies. All other files in rtl/core use it.
package lwck_pkg;

  localparam int unsigned CordicW = 34;
  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [CordicW-1:0] RadPerCdeg = 34'sd187403;

  localparam logic [1:0] LegIdx0 = 2'd0;
  localparam logic [1:0] LegIdx1 = 2'd1;
  localparam logic [1:0] LegIdx2 = 2'd2;

  localparam logic [1:0] RegLegLength = 2'd0;
  localparam logic [1:0] RegBodyDrop = 2'd1;
  localparam logic [1:0] RegMountRadius = 2'd2;

  typedef struct packed {
    logic                      vld;
    logic [1:0]                leg;
    logic                      negp;
    logic                      negl;
    logic signed [CordicW-1:0] xp;
    logic signed [CordicW-1:0] yp;
    logic signed [CordicW-1:0] zp;
    logic signed [CordicW-1:0] xl;
    logic signed [CordicW-1:0] yl;
    logic signed [CordicW-1:0] zl;
  } cordic_t;

  function automatic logic signed [CordicW-1:0] atan_q30(input int unsigned idx);
    logic signed [CordicW-1:0] r;
    case (idx)
      0: r = 34'sh03243F6A8;
      1: r = 34'sh01DAC6705;
      2: r = 34'sh00FADBAFC;
      3: r = 34'sh007F56EA6;
      4: r = 34'sh003FEAB76;
      5: r = 34'sh001FFD55B;
      6: r = 34'sh000FFFAAA;
      7: r = 34'sh0007FFF55;
      8: r = 34'sh0003FFFEA;
      9: r = 34'sh0001FFFFD;
      10: r = 34'sh0000FFFFF;
      11: r = 34'sh00007FFFF;
      12: r = 34'sh00003FFFF;
      13: r = 34'sh00001FFFF;
      14: r = 34'sh00000FFFF;
      15: r = 34'sh000007FFF;
      16: r = 34'sh000003FFF;
      17: r = 34'sh000001FFF;
      18: r = 34'sh000000FFF;
      19: r = 34'sh0000007FF;
      20: r = 34'sh0000003FF;
      21: r = 34'sh0000001FF;
      22: r = 34'sh0000000FF;
      23: r = 34'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] mount_cos(input logic [1:0] leg);
    logic signed [15:0] r;
    case (leg)
      LegIdx1, LegIdx2: r = -16'sd16384;
      default: r = 16'sd32767;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] mount_sin(input logic [1:0] leg);
    logic signed [15:0] r;
    case (leg)
      LegIdx1: r = 16'sd28378;
      LegIdx2: r = -16'sd28378;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/leg_wheel_center_kinematics_top.sv
// Throughput is one transaction per cycle; the whole pipeline holds only while a result is stalled.
// The pan and lift sines and cosines come from one chain of CORDIC_STAGES rotation cells.
// Reset clears all valid bits and loads leg_length 4000, body_drop 1700, mount_radius 2000.
// Depends on lwck_pkg, lwck_prep, lwck_cell and lwck_post.
module leg_wheel_center_kinematics_top #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         leg_index_i,
  input  logic signed [15:0] pan_angle_i,
  input  logic signed [15:0] lift_angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic [1:0]         leg_echo_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  logic              en;
  logic [13:0]       leg_length_q, body_drop_q, mount_radius_q;
  lwck_pkg::cordic_t chain [CORDIC_STAGES+1];

  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leg_length_q <= 14'd4000;
      body_drop_q <= 14'd1700;
      mount_radius_q <= 14'd2000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        lwck_pkg::RegLegLength: leg_length_q <= cfg_data_i[13:0];
        lwck_pkg::RegBodyDrop: body_drop_q <= cfg_data_i[13:0];
        lwck_pkg::RegMountRadius: mount_radius_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  lwck_prep u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .leg_i  (leg_index_i),
    .pan_i  (pan_angle_i),
    .lift_i (lift_angle_i),
    .cell_o (chain[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    lwck_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  lwck_post u_post (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .cell_i         (chain[CORDIC_STAGES]),
    .leg_length_i   (leg_length_q),
    .body_drop_i    (body_drop_q),
    .mount_radius_i (mount_radius_q),
    .vld_o          (out_valid_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o),
    .leg_o          (leg_echo_o)
  );

endmodule

FILE: rtl/core/lwck_prep.sv
// Angle reduction and radian scaling that load the first CORDIC cell.
// Depends on lwck_pkg.
module lwck_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [1:0]          leg_i,
  input  logic signed [15:0]  pan_i,
  input  logic signed [15:0]  lift_i,
  output lwck_pkg::cordic_t   cell_o
);

  function automatic logic [18:0] fold(input logic signed [17:0] a_in);
    logic signed [17:0] a;
    logic               neg;
    a = a_in;
    neg = 1'b0;
    if (a >= 18'sd18000) begin
      a = a - 18'sd36000;
    end else if (a < -18'sd18000) begin
      a = a + 18'sd36000;
    end
    if (a > 18'sd9000) begin
      a = 18'sd18000 - a;
      neg = 1'b1;
    end else if (a < -18'sd9000) begin
      a = -18'sd18000 - a;
      neg = 1'b1;
    end
    return {neg, a};
  endfunction

  logic signed [17:0] mnt;
  logic signed [17:0] p_raw;
  logic [18:0]        fp;
  logic [18:0]        fl;
  logic signed [17:0] ap;
  logic signed [17:0] al;
  lwck_pkg::cordic_t  cell_d;
  lwck_pkg::cordic_t  cell_q;

  always_comb begin
    case (leg_i)
      lwck_pkg::LegIdx1: mnt = 18'sd12000;
      lwck_pkg::LegIdx2: mnt = -18'sd12000;
      default: mnt = 18'sd0;
    endcase
    p_raw = 18'({{2{pan_i[15]}}, pan_i}) - mnt;
    fp = fold(p_raw);
    fl = fold(18'({{2{lift_i[15]}}, lift_i}));
    ap = fp[17:0];
    al = fl[17:0];
    cell_d.vld = vld_i;
    cell_d.leg = leg_i;
    cell_d.negp = fp[18];
    cell_d.negl = fl[18];
    cell_d.xp = lwck_pkg::CordicGain;
    cell_d.yp = '0;
    cell_d.zp = $signed({{16{ap[17]}}, ap}) * lwck_pkg::RadPerCdeg;
    cell_d.xl = lwck_pkg::CordicGain;
    cell_d.yl = '0;
    cell_d.zl = $signed({{16{al[17]}}, al}) * lwck_pkg::RadPerCdeg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

FILE: rtl/core/lwck_cell.sv
// One CORDIC rotation cell that advances both the pan and the lift vector by one step.
// Depends on lwck_pkg.
module lwck_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  lwck_pkg::cordic_t cell_i,
  output lwck_pkg::cordic_t cell_o
);

  localparam logic signed [lwck_pkg::CordicW-1:0] Atan = lwck_pkg::atan_q30(STAGE);

  lwck_pkg::cordic_t cell_d;
  lwck_pkg::cordic_t cell_q;

  always_comb begin
    cell_d = cell_i;
    if (!cell_i.zp[lwck_pkg::CordicW-1]) begin
      cell_d.xp = cell_i.xp - (cell_i.yp >>> STAGE);
      cell_d.yp = cell_i.yp + (cell_i.xp >>> STAGE);
      cell_d.zp = cell_i.zp - Atan;
    end else begin
      cell_d.xp = cell_i.xp + (cell_i.yp >>> STAGE);
      cell_d.yp = cell_i.yp - (cell_i.xp >>> STAGE);
      cell_d.zp = cell_i.zp + Atan;
    end
    if (!cell_i.zl[lwck_pkg::CordicW-1]) begin
      cell_d.xl = cell_i.xl - (cell_i.yl >>> STAGE);
      cell_d.yl = cell_i.yl + (cell_i.xl >>> STAGE);
      cell_d.zl = cell_i.zl - Atan;
    end else begin
      cell_d.xl = cell_i.xl + (cell_i.yl >>> STAGE);
      cell_d.yl = cell_i.yl - (cell_i.xl >>> STAGE);
      cell_d.zl = cell_i.zl + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

FILE: rtl/core/lwck_post.sv
// Rounds the CORDIC results to Q1.15, forms the three coordinates and holds the output register.
// Depends on lwck_pkg.
module lwck_post (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  lwck_pkg::cordic_t  cell_i,
  input  logic [13:0]        leg_length_i,
  input  logic [13:0]        body_drop_i,
  input  logic [13:0]        mount_radius_i,
  output logic               vld_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic [1:0]         leg_o
);

  function automatic logic signed [15:0] rq15(input logic signed [33:0] x);
    logic signed [33:0] t;
    t = (x + 34'sd16384) >>> 15;
    if (t > 34'sd32767) begin
      return 16'sd32767;
    end else if (t < -34'sd32768) begin
      return -16'sd32768;
    end
    return t[15:0];
  endfunction

  function automatic logic signed [15:0] fin(input logic signed [48:0] acc);
    logic signed [48:0] t;
    t = (acc + (49'sd1 <<< 29)) >>> 30;
    if (t > 49'sd32767) begin
      return 16'sd32767;
    end else if (t < -49'sd32768) begin
      return -16'sd32768;
    end
    return t[15:0];
  endfunction

  logic               a_vld_q;
  logic [1:0]         a_leg_q;
  logic signed [15:0] a_sp_q, a_cp_q, a_ss_q, a_cs_q;

  logic               b_vld_q;
  logic [1:0]         b_leg_q;
  logic signed [15:0] b_sp_q, b_cp_q;
  logic signed [31:0] b_ls_q, b_lc_q, b_rc_q, b_rs_q;

  logic               c_vld_q;
  logic [1:0]         c_leg_q;
  logic signed [47:0] c_px_q, c_py_q;
  logic signed [31:0] c_lc_q, c_rc_q, c_rs_q;

  logic               o_vld_q;
  logic [1:0]         o_leg_q;
  logic signed [15:0] o_x_q, o_y_q, o_z_q;

  logic signed [48:0] acc_x, acc_y, acc_z;

  always_comb begin
    acc_x = (49'(c_rc_q) <<< 15) + 49'(c_px_q);
    acc_y = (49'(c_rs_q) <<< 15) - 49'(c_py_q);
    acc_z = -(49'(c_lc_q) <<< 15) - (49'($signed({1'b0, body_drop_i})) <<< 30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= cell_i.vld;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      o_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_leg_q <= cell_i.leg;
      a_cp_q <= rq15(cell_i.negp ? -cell_i.xp : cell_i.xp);
      a_sp_q <= rq15(cell_i.yp);
      a_cs_q <= rq15(cell_i.negl ? -cell_i.xl : cell_i.xl);
      a_ss_q <= rq15(cell_i.yl);

      b_leg_q <= a_leg_q;
      b_sp_q <= a_sp_q;
      b_cp_q <= a_cp_q;
      b_ls_q <= $signed({1'b0, leg_length_i}) * a_ss_q;
      b_lc_q <= $signed({1'b0, leg_length_i}) * a_cs_q;
      b_rc_q <= $signed({1'b0, mount_radius_i}) * lwck_pkg::mount_cos(a_leg_q);
      b_rs_q <= $signed({1'b0, mount_radius_i}) * lwck_pkg::mount_sin(a_leg_q);

      c_leg_q <= b_leg_q;
      c_px_q <= b_ls_q * b_cp_q;
      c_py_q <= b_ls_q * b_sp_q;
      c_lc_q <= b_lc_q;
      c_rc_q <= b_rc_q;
      c_rs_q <= b_rs_q;

      o_leg_q <= c_leg_q;
      o_x_q <= fin(acc_x);
      o_y_q <= fin(acc_y);
      o_z_q <= fin(acc_z);
    end
  end

  assign vld_o = o_vld_q;
  assign pos_x_o = o_x_q;
  assign pos_y_o = o_y_q;
  assign pos_z_o = o_z_q;
  assign leg_o = o_leg_q;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for leg_wheel_center_kinematics_top.
// It predicts each wheel center position with its own CORDIC model and needs lwck_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned Stages = 16;
  localparam logic [1:0] RegUnused = 2'd3;
  localparam logic [1:0] LegSpare = 2'd3;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [1:0]         leg;
  } position_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         leg_index;
  logic signed [15:0] pan_angle;
  logic signed [15:0] lift_angle;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [1:0]         leg_echo;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  longint    link_len;
  longint    drop_len;
  longint    radius_len;
  position_t pos_expected[$];
  int        errors;
  int        positions_checked;
  int        sender_idle_pct;
  int        receiver_idle_pct;

  const longint AtanTable[Stages] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
  };

  leg_wheel_center_kinematics_top #(.CORDIC_STAGES(Stages)) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .leg_index_i (leg_index),
    .pan_angle_i (pan_angle),
    .lift_angle_i(lift_angle),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .pos_x_o     (pos_x),
    .pos_y_o     (pos_y),
    .pos_z_o     (pos_z),
    .leg_echo_o  (leg_echo),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint clamp16(longint v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic void angle_sin_cos(longint a, output longint s, output longint c);
    longint x, y, z, nx, ny;
    bit     flip;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (a >= 18000) a -= 36000;
    else if (a < -18000) a += 36000;
    if (a > 9000) begin
      a = 18000 - a;
      flip = 1'b1;
    end else if (a < -9000) begin
      a = -18000 - a;
      flip = 1'b1;
    end
    z = a * 187403;
    for (int i = 0; i < Stages; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= AtanTable[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += AtanTable[i];
      end
      x = nx;
      y = ny;
    end
    if (flip) x = -x;
    c = clamp16((x + 16384) >>> 15);
    s = clamp16((y + 16384) >>> 15);
  endfunction

  function automatic position_t predict_wheel_center(logic [1:0] leg, logic signed [15:0] pan,
                                                     logic signed [15:0] lift);
    position_t r;
    longint    mount_deg, mc, ms, sp, cp, sl, cl, ax, ay, az;
    case (leg)
      lwck_pkg::LegIdx1: begin mount_deg = 12000; mc = -16384; ms = 28378; end
      lwck_pkg::LegIdx2: begin mount_deg = -12000; mc = -16384; ms = -28378; end
      default: begin mount_deg = 0; mc = 32767; ms = 0; end
    endcase
    angle_sin_cos(longint'(pan) - mount_deg, sp, cp);
    angle_sin_cos(longint'(lift), sl, cl);
    ax = radius_len * mc * 32768 + link_len * sl * cp;
    ay = radius_len * ms * 32768 - link_len * sl * sp;
    az = -(link_len * cl * 32768) - (drop_len <<< 30);
    r.x = 16'(clamp16((ax + (64'sd1 <<< 29)) >>> 30));
    r.y = 16'(clamp16((ay + (64'sd1 <<< 29)) >>> 30));
    r.z = 16'(clamp16((az + (64'sd1 <<< 29)) >>> 30));
    r.leg = leg;
    return r;
  endfunction

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  always @(posedge clk) begin
    position_t e;
    if (out_valid && !out_stall) begin
      if (pos_expected.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d leg=%0d", $time, pos_x, pos_y,
                 pos_z, leg_echo);
        errors++;
      end else begin
        e = pos_expected.pop_front();
        positions_checked++;
        if (pos_x !== e.x) begin
          $display("%0t: pos_x expected %0d actual %0d", $time, e.x, pos_x);
          errors++;
        end
        if (pos_y !== e.y) begin
          $display("%0t: pos_y expected %0d actual %0d", $time, e.y, pos_y);
          errors++;
        end
        if (pos_z !== e.z) begin
          $display("%0t: pos_z expected %0d actual %0d", $time, e.z, pos_z);
          errors++;
        end
        if (leg_echo !== e.leg) begin
          $display("%0t: leg_echo expected %0d actual %0d", $time, e.leg, leg_echo);
          errors++;
        end
      end
    end
  end

  task automatic send_query(logic [1:0] leg, logic signed [15:0] pan, logic signed [15:0] lift);
    bit accepted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    leg_index = leg;
    pan_angle = pan;
    lift_angle = lift;
    accepted = 1'b0;
    while (!accepted) begin
      @(posedge clk);
      if (!in_stall) begin
        accepted = 1'b1;
        pos_expected.push_back(predict_wheel_center(leg, pan, lift));
      end
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pos_expected.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lwck_pkg::RegLegLength: link_len = data[13:0];
      lwck_pkg::RegBodyDrop: drop_len = data[13:0];
      lwck_pkg::RegMountRadius: radius_len = data[13:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [15:0] random_angle();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(36000)) - 18000);
  endfunction

  task automatic test_directed();
    logic signed [15:0] angles[12] = '{0, 18000, -18000, 17999, -17999, 9000, -9000, 9001,
                                       -9001, 12000, 32767, -32768};
    for (int i = 0; i < 12; i++) send_query(2'(i % 4), angles[i], angles[11 - i]);
    for (int l = 0; l < 4; l++) send_query(2'(l), 16'sd4500, 16'sd3000);
    send_query(LegSpare, -16'sd12000, 16'sd9000);
    send_query(lwck_pkg::LegIdx1, 16'sh5555, 16'shAAAA);
    drain_results();
  endtask

  task automatic test_register_extremes();
    write_register(lwck_pkg::RegLegLength, 16'hC000);
    write_register(lwck_pkg::RegBodyDrop, 16'h0000);
    write_register(lwck_pkg::RegMountRadius, 16'h0000);
    for (int l = 0; l < 4; l++) send_query(2'(l), random_angle(), random_angle());
    drain_results();
    write_register(lwck_pkg::RegLegLength, 16'hFFFF);
    write_register(lwck_pkg::RegBodyDrop, 16'hFFFF);
    write_register(lwck_pkg::RegMountRadius, 16'hFFFF);
    write_register(RegUnused, 16'h1234);
    send_query(lwck_pkg::LegIdx0, 16'sd0, 16'sd9000);
    send_query(lwck_pkg::LegIdx0, 16'sd0, 16'sd0);
    send_query(lwck_pkg::LegIdx0, 16'sd18000, 16'sd18000);
    send_query(lwck_pkg::LegIdx1, -16'sd6000, 16'sd9000);
    send_query(lwck_pkg::LegIdx2, 16'sd6000, -16'sd9000);
    send_query(LegSpare, 16'sd18000, -16'sd9000);
    for (int i = 0; i < 10; i++) send_query(2'($urandom), random_angle(), random_angle());
    drain_results();
  endtask

  task automatic test_random_queries(int count, int snd_pct, int rcv_pct);
    sender_idle_pct = snd_pct;
    receiver_idle_pct = rcv_pct;
    write_register(lwck_pkg::RegLegLength, 16'($urandom));
    write_register(lwck_pkg::RegBodyDrop, 16'($urandom_range(3000)));
    write_register(lwck_pkg::RegMountRadius, 16'($urandom_range(4000)));
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 149) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end else if (i % 150 == 0) begin
        sender_idle_pct = snd_pct;
        receiver_idle_pct = rcv_pct;
      end
      send_query(2'($urandom), random_angle(), random_angle());
    end
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    leg_index = '0;
    pan_angle = '0;
    lift_angle = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    positions_checked = 0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    link_len = 4000;
    drop_len = 1700;
    radius_len = 2000;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_register_extremes();
    test_random_queries(610, 30, 71);
    test_random_queries(610, 71, 30);
    test_random_queries(610, 0, 0);
    repeat (Stages + 10) @(negedge clk);
    $display("Checked %0d wheel center positions over all legs, angle wraps,", positions_checked);
    $display("register extremes, saturation and three idle patterns.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding.", pos_expected.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
